// File: rtl/core/spq_pkg.sv
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int TAG_W  = 16;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } spq_op_t;

  typedef struct packed {
    spq_op_t op;
    prio_t   prio;
  } spq_ctrl_t;

  typedef struct packed {
    logic              cmd;
    logic [TAG_W-1:0]  job_tag;
    prio_t             job_priority;
  } spq_in_t;

  typedef struct packed {
    logic              popped_valid;
    logic [TAG_W-1:0]  popped_tag;
    prio_t             popped_priority;
    logic              was_empty;
    logic              overflow;
    logic [OCC_W-1:0]  occupancy;
  } spq_out_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_cell.sv
// one slot of the sorted chain: holds a job and trades it with its neighbors
`default_nettype none

module spq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spq_pkg::spq_ctrl_t     ctrl,
  input  logic [TAG_BITS-1:0]    new_tag,
  input  logic                   left_valid,
  input  logic                   left_shift,
  input  logic [TAG_BITS-1:0]    left_tag,
  input  spq_pkg::prio_t         left_prio,
  input  logic                   right_valid,
  input  logic [TAG_BITS-1:0]    right_tag,
  input  spq_pkg::prio_t         right_prio,
  output logic                   valid,
  output logic                   shift,
  output logic [TAG_BITS-1:0]    tag,
  output spq_pkg::prio_t         prio
);
  import spq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  prio_t               prio_r, prio_nxt;
  logic                take_left;
  logic                take_new;

  // stored job moves right when the new job sorts in front of it
  assign shift = valid_r && (prio_r > ctrl.prio);

  // insertion point: left neighbor stays put and holds a job, this slot moves or is free
  assign take_left = left_shift;
  assign take_new  = !left_shift && left_valid && (shift || !valid_r);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    unique case (ctrl.op)
      OP_PUSH: begin
        if (take_left) begin
          valid_nxt = 1'b1;
          tag_nxt   = left_tag;
          prio_nxt  = left_prio;
        end else if (take_new) begin
          valid_nxt = 1'b1;
          tag_nxt   = new_tag;
          prio_nxt  = ctrl.prio;
        end
      end
      OP_POP: begin
        valid_nxt = right_valid;
        tag_nxt   = right_tag;
        prio_nxt  = right_prio;
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign prio  = prio_r;

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
// top level of the stable sorted priority queue built from a chain of slot cells
//
// usage:
//   - command channel: a transfer happens at a rising edge with start high and busy low;
//     in_item.cmd selects push (job_tag, job_priority) or pop of the front job
//   - busy is held low: a command is taken every cycle, so one item per cycle sustained
//   - result channel: out_strobe is high for exactly one cycle, the cycle right after
//     the command transfer, with out_item valid in that cycle
//   - the receiver cannot stall; each result must be taken in its strobe cycle
//   - every slot compares the new priority with its own in the same cycle, so a push
//     ripples the tail of the queue one slot right at once; a pop moves
//     every slot one place left
//   - equal priorities stay in arrival order: a new job lands behind all jobs with
//     lower or equal priority
//   - push on a full queue is dropped and flagged with overflow; pop on an empty
//     queue leaves the state alone and sets was_empty
//   - occupancy reports the job count after the command, modulo 32
//   - synchronous active-low reset empties the queue at once; slot contents are not
//     cleared, only their valid bits
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::spq_in_t   in_item,
  output logic               out_strobe,
  output spq_pkg::spq_out_t  out_item
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 xfer;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 full;
  logic                 empty;
  spq_ctrl_t            ctrl;
  logic [TAG_BITS-1:0]  new_tag;

  // chain links, one entry per slot
  logic                 cell_valid [CAPACITY];
  logic                 cell_shift [CAPACITY];
  logic [TAG_BITS-1:0]  cell_tag   [CAPACITY];
  prio_t                cell_prio  [CAPACITY];

  logic                 strobe_r, strobe_nxt;
  spq_out_t             out_r, out_nxt;

  // one command per cycle, no backpressure on the command side
  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // stored tag keeps the low TAG_BITS bits, zero filled when wider
  assign new_tag = TAG_BITS'(in_item.job_tag);

  // decode the command into the chain operation
  always_comb begin
    ctrl.op   = OP_HOLD;
    ctrl.prio = in_item.job_priority;
    count_nxt = count_r;
    if (xfer) begin
      unique case (in_item.cmd)
        CMD_PUSH: begin
          if (!full) begin
            ctrl.op   = OP_PUSH;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (!empty) begin
            ctrl.op   = OP_POP;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // the slot chain, front of the queue at slot 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                left_valid;
    logic                left_shift;
    logic [TAG_BITS-1:0] left_tag;
    prio_t               left_prio;
    logic                right_valid;
    logic [TAG_BITS-1:0] right_tag;
    prio_t               right_prio;

    if (i == 0) begin : g_head
      // head sees a held, non-moving neighbor so it can take the new job
      assign left_valid = 1'b1;
      assign left_shift = 1'b0;
      assign left_tag   = '0;
      assign left_prio  = '0;
    end else begin : g_link_l
      assign left_valid = cell_valid[i-1];
      assign left_shift = cell_shift[i-1];
      assign left_tag   = cell_tag[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // tail refills with an empty slot on a pop
      assign right_valid = 1'b0;
      assign right_tag   = '0;
      assign right_prio  = '0;
    end else begin : g_link_r
      assign right_valid = cell_valid[i+1];
      assign right_tag   = cell_tag[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_tag     (new_tag),
      .left_valid  (left_valid),
      .left_shift  (left_shift),
      .left_tag    (left_tag),
      .left_prio   (left_prio),
      .right_valid (right_valid),
      .right_tag   (right_tag),
      .right_prio  (right_prio),
      .valid       (cell_valid[i]),
      .shift       (cell_shift[i]),
      .tag         (cell_tag[i]),
      .prio        (cell_prio[i])
    );
  end

  // result word, registered at the command transfer
  always_comb begin
    strobe_nxt              = xfer;
    out_nxt.popped_valid    = 1'b0;
    out_nxt.popped_tag      = '0;
    out_nxt.popped_priority = '0;
    out_nxt.was_empty       = 1'b0;
    out_nxt.overflow        = 1'b0;
    out_nxt.occupancy       = OCC_W'(count_nxt);
    unique case (in_item.cmd)
      CMD_PUSH: begin
        out_nxt.overflow = full;
      end
      CMD_POP: begin
        out_nxt.was_empty = empty;
        if (!empty) begin
          out_nxt.popped_valid    = 1'b1;
          out_nxt.popped_tag      = TAG_W'(cell_tag[0]);
          out_nxt.popped_priority = cell_prio[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
`default_nettype none

module spq_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               out_strobe,
  input  spq_pkg::spq_out_t  out_item
);
  import spq_pkg::*;

  // every command transfer gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe)
    else $error("missing result after command transfer");

  // no result without a command transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_strobe)
    else $error("result without command transfer");

  // a result carries at most one of popped, empty and overflow
  a_one_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot0({out_item.popped_valid, out_item.was_empty, out_item.overflow}))
    else $error("conflicting status flags");

  // an empty pop sees nothing stored, a dropped push sees a full queue
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.was_empty || out_item.overflow) |->
      (out_item.was_empty && out_item.occupancy == '0) ||
      (out_item.overflow && out_item.occupancy == OCC_W'(CAPACITY)))
    else $error("occupancy disagrees with status flag");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the stable sorted priority queue
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int DRAIN_LIMIT = 64;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  spq_in_t  in_item;
  logic     out_strobe;
  spq_out_t out_item;

  // shadow of the queue contents, front job at index 0
  logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
  prio_t            held_prio [QUEUE_DEPTH];
  int               held_count;

  // outcomes predicted at command transfer, waiting for their strobe
  spq_out_t outcomes_due [$];
  int       errors;
  int       idle_pct;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH),
    .TAG_BITS(TAG_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case a transfer or a strobe never comes
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // advance the shadow queue by one command and return what the block should report
  function automatic spq_out_t queue_outcome(spq_in_t cmd_item);
    spq_out_t res;
    int       pos;
    res = '0;
    if (cmd_item.cmd == CMD_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        // full: job dropped, contents untouched
        res.overflow = 1'b1;
      end else begin
        // land behind every job of lower or equal priority
        pos = 0;
        while (pos < held_count && held_prio[pos] <= cmd_item.job_priority) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_tag[i]  = held_tag[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos]  = cmd_item.job_tag;
        held_prio[pos] = cmd_item.job_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.was_empty = 1'b1;
      end else begin
        res.popped_valid    = 1'b1;
        res.popped_tag      = held_tag[0];
        res.popped_priority = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_tag[i-1]  = held_tag[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  function automatic spq_in_t make_push(logic [TAG_W-1:0] tag, prio_t prio);
    spq_in_t c;
    c.cmd          = CMD_PUSH;
    c.job_tag      = tag;
    c.job_priority = prio;
    return c;
  endfunction

  // pop carries random tag and priority bits, which the block must ignore
  function automatic spq_in_t make_pop();
    spq_in_t c;
    c.cmd          = CMD_POP;
    c.job_tag      = TAG_W'($urandom);
    c.job_priority = prio_t'($urandom);
    return c;
  endfunction

  // mix of tight ranges (many ties), full range and the extremes
  function automatic prio_t rand_priority();
    prio_t p;
    case ($urandom_range(3))
      0: p = prio_t'($signed($urandom_range(4)) - 2);
      1: begin
        case ($urandom_range(3))
          0: p = 16'sh8000;
          1: p = 16'sh7fff;
          2: p = '0;
          default: p = '1;
        endcase
      end
      default: p = prio_t'($urandom);
    endcase
    return p;
  endfunction

  // one command transfer; call right after a rising edge
  task automatic issue_cmd(spq_in_t item);
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // transfer happened at this edge
    outcomes_due.push_back(queue_outcome(item));
    // sender gap, at random, for the current idle rate
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic empty_out();
    while (held_count > 0) issue_cmd(make_pop());
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  // result side: the strobe cycle ends at this edge, so values sampled here are the result
  always @(posedge clk) begin
    spq_out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("popped_valid", want.popped_valid, out_item.popped_valid);
        check_field("popped_tag", want.popped_tag, out_item.popped_tag);
        check_field("popped_priority", want.popped_priority, out_item.popped_priority);
        check_field("was_empty", want.was_empty, out_item.was_empty);
        check_field("overflow", want.overflow, out_item.overflow);
        check_field("occupancy", want.occupancy, out_item.occupancy);
      end
    end
  end

  // pop from an empty queue, right after reset
  task automatic test_empty_pop();
    issue_cmd(make_pop());
    issue_cmd(make_pop());
  endtask

  // extreme tags and priorities, drained in priority order
  task automatic test_extremes();
    issue_cmd(make_push(16'hffff, 16'sh7fff));
    issue_cmd(make_push(16'h0000, 16'sh8000));
    issue_cmd(make_push(16'haaaa, 16'sh0000));
    issue_cmd(make_push(16'h5555, 16'shffff));
    empty_out();
    issue_cmd(make_pop());
  endtask

  // equal priorities must leave in arrival order
  task automatic test_stable_order();
    issue_cmd(make_push(16'h0001, 16'sh0005));
    issue_cmd(make_push(16'h0002, 16'sh0005));
    issue_cmd(make_push(16'h0003, 16'sh0004));
    issue_cmd(make_push(16'h0004, 16'sh0005));
    issue_cmd(make_push(16'h0005, 16'sh0004));
    empty_out();
  endtask

  // fill to the brim, push into a full queue, then drain past empty
  task automatic test_overflow();
    while (held_count < QUEUE_DEPTH) issue_cmd(make_push(TAG_W'($urandom), rand_priority()));
    repeat (3) issue_cmd(make_push(TAG_W'($urandom), rand_priority()));
    empty_out();
    issue_cmd(make_pop());
  endtask

  // bursts with a varying push share so the queue swings between empty and full
  task automatic test_random(int n_items);
    int push_pct;
    int left;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 75;
        default: push_pct = 92;
      endcase
      repeat ($urandom_range(30, 8)) begin
        if (left > 0) begin
          if ($urandom_range(99) < push_pct)
            issue_cmd(make_push(TAG_W'($urandom), rand_priority()));
          else
            issue_cmd(make_pop());
          left--;
        end
      end
    end
  endtask

  initial begin
    int waited;
    errors     = 0;
    held_count = 0;
    idle_pct   = 14;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pop();
    test_extremes();
    test_stable_order();
    test_overflow();

    // sender idles seldom, then often, then never
    idle_pct = 14;
    test_random(200);
    idle_pct = 88;
    test_random(200);
    idle_pct = 0;
    test_random(200);
    test_overflow();

    // quiet the command side and let the last strobes arrive
    start <= 1'b0;
    waited = 0;
    while (outcomes_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %h, actual none",
               $time, outcomes_due.size(), outcomes_due[0]);
      errors++;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
